@@ rtl/scc_pkg.sv @@
// Package for the strongly connected components block.
// Holds sizes, command and status codes, and the controller state type.
// No dependencies.
package scc_pkg;

	localparam int MAX_VERTICES_DEF = 1024;
	localparam int MAX_EDGES_DEF    = 4096;
	localparam int CNT_W            = 11;
	localparam logic [CNT_W-1:0] VCOUNT_RST = 11'd1024;

	typedef enum logic [1:0] {
		CMD_ADD   = 2'd0,
		CMD_BUILD = 2'd1,
		CMD_QUERY = 2'd2,
		CMD_NOP   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_RANGE     = 2'd1,
		ST_FULL      = 2'd2,
		ST_NOT_BUILT = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_QWAIT,
		S_CLR,
		S_OUT_RD,
		S_OUT_CHK,
		S_SCAN,
		S_EDGE_CHK,
		S_VIS_CHK,
		S_POP_WAIT,
		S_REV_RD,
		S_REV_VIS_RD,
		S_REV_CHK,
		S_DONE
	} state_t;

endpackage

@@ rtl/strongly_connected_components.sv @@
// Strongly connected components (two-pass depth-first labeling) over streamed edges.
// Add, unused code and failed query answer the cycle after acceptance, one item per
// cycle while idle; a good query compares the labels in S_QWAIT, busy until answered.
// Build: per pass a clear, a start loop, and per visited vertex a scan of all edges.
// Reset (arst_n low) empties the edge store, clears built flag and count, vertex_count 1024.
// Results are strobed for one cycle; no stall.
module strongly_connected_components
	import scc_pkg::*;
#(
	parameter int MAX_VERTICES = MAX_VERTICES_DEF,
	parameter int MAX_EDGES    = MAX_EDGES_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [1:0]       command,
	input  logic [10:0]      vertex_a,
	input  logic [10:0]      vertex_b,
	output logic             busy,
	output logic             result_valid,
	output logic             same_component,
	output logic [10:0]      component_total,
	output logic [1:0]       status,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [2:0]       paddr,
	input  logic [31:0]      pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	localparam int VW  = $clog2(MAX_VERTICES);
	localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int EW  = $clog2(MAX_EDGES + 1);

	// memories
	logic           vis_mem [MAX_VERTICES];
	logic [VW-1:0]  src_mem [MAX_EDGES];
	logic [VW-1:0]  tgt_mem [MAX_EDGES];
	logic [VW-1:0]  fin_mem [MAX_VERTICES];
	logic [VW-1:0]  lab_mem [MAX_VERTICES];
	logic [VW-1:0]  stkv_mem [MAX_VERTICES];
	logic [EW-1:0]  stke_mem [MAX_VERTICES];

	state_t         state_q, state_d;
	logic [CNT_W-1:0] vc_q;
	logic [CNT_W-1:0] n;
	logic           built_q, rev_q;
	logic [EW-1:0]  edges_q, cur_e_q;
	logic [VW:0]    i_q, fin_q, count_q, comp_q, sp_q, clr_q;
	logic [VW-1:0]  cur_v_q, to_q;

	// memory ports
	logic           vis_we, vis_wd, vis_rd_q;
	logic [VW-1:0]  vis_wa, vis_ra;
	logic [VW-1:0]  src_rd_q, tgt_rd_q, fin_rd_q, labA_q, labB_q, stkv_rd_q;
	logic [EW-1:0]  stke_rd_q;
	logic [VW-1:0]  e_from, e_to;

	logic           accept, cfg_wr, in_range, walk_last;
	logic           edge_cnt_lt, e_match, to_in;
	logic           add_ok, rv_d;
	status_t        idle_status;
	logic [VW-1:0]  a_idx, b_idx;

	assign accept  = start && !busy;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign pready  = 1'b1;
	assign prdata  = paddr[2] ? 32'd0 : 32'(vc_q);
	assign busy    = (state_q != S_IDLE);
	assign n       = (32'(vc_q) > MAX_VERTICES) ? CNT_W'(MAX_VERTICES) : vc_q;
	assign in_range = (vertex_a >= 11'd1) && (vertex_a <= n) &&
		(vertex_b >= 11'd1) && (vertex_b <= n);
	assign a_idx   = VW'(vertex_a - 11'd1);
	assign b_idx   = VW'(vertex_b - 11'd1);
	assign e_from  = rev_q ? tgt_rd_q : src_rd_q;
	assign e_to    = rev_q ? src_rd_q : tgt_rd_q;
	assign edge_cnt_lt = cur_e_q < edges_q;
	assign e_match = (e_from == cur_v_q) && to_in;
	assign to_in   = 32'(e_to) < 32'(n);
	assign walk_last = (sp_q == (VW+1)'(1));
	assign add_ok  = accept && (command == CMD_ADD) && in_range &&
		(32'(edges_q) < MAX_EDGES);

	// result strobe: immediate answers, query readout and build end
	assign rv_d = (accept && (command != CMD_BUILD) &&
		!(command == CMD_QUERY && in_range && built_q)) ||
		(state_q == S_QWAIT) || (state_q == S_DONE);

	// status of an immediately answered transaction
	always_comb begin
		idle_status = ST_OK;
		case (command)
			CMD_ADD: begin
				if (!in_range)
					idle_status = ST_RANGE;
				else if (32'(edges_q) >= MAX_EDGES)
					idle_status = ST_FULL;
			end
			CMD_QUERY: begin
				if (!in_range)
					idle_status = ST_RANGE;
				else if (!built_q)
					idle_status = ST_NOT_BUILT;
			end
			default: idle_status = ST_OK;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept && command == CMD_BUILD)
					state_d = S_CLR;
				else if (accept && command == CMD_QUERY && in_range && built_q)
					state_d = S_QWAIT;
			end
			S_QWAIT: state_d = S_IDLE;
			S_CLR: begin
				if (clr_q == (VW+1)'(MAX_VERTICES - 1))
					state_d = rev_q ? S_REV_RD : S_OUT_RD;
			end
			S_OUT_RD: state_d = (32'(i_q) < 32'(n)) ? S_OUT_CHK : S_CLR;
			S_OUT_CHK: state_d = vis_rd_q ? S_OUT_RD : S_SCAN;
			S_SCAN: begin
				if (edge_cnt_lt)
					state_d = S_EDGE_CHK;
				else if (walk_last)
					state_d = rev_q ? S_REV_RD : S_OUT_RD;
				else
					state_d = S_POP_WAIT;
			end
			S_EDGE_CHK: state_d = e_match ? S_VIS_CHK : S_SCAN;
			S_VIS_CHK: state_d = S_SCAN;
			S_POP_WAIT: state_d = S_SCAN;
			S_REV_RD: state_d = (i_q != '0) ? S_REV_VIS_RD : S_DONE;
			S_REV_VIS_RD: state_d = (32'(fin_rd_q) < 32'(n)) ? S_REV_CHK : S_REV_RD;
			S_REV_CHK: state_d = vis_rd_q ? S_REV_RD : S_SCAN;
			S_DONE: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// visited memory controls
	always_comb begin
		vis_we = 1'b0;
		vis_wd = 1'b1;
		vis_wa = cur_v_q;
		vis_ra = to_q;
		case (state_q)
			S_CLR: begin
				vis_we = 1'b1;
				vis_wd = 1'b0;
				vis_wa = clr_q[VW-1:0];
			end
			S_OUT_RD: vis_ra = i_q[VW-1:0];
			S_OUT_CHK: begin
				vis_we = !vis_rd_q;
				vis_wa = i_q[VW-1:0];
			end
			S_EDGE_CHK: vis_ra = e_to;
			S_REV_VIS_RD: vis_ra = fin_rd_q;
			S_REV_CHK: vis_we = !vis_rd_q;
			S_VIS_CHK: begin
				vis_we = !vis_rd_q;
				vis_wa = to_q;
			end
			default: vis_we = 1'b0;
		endcase
	end

	// memory arrays
	always_ff @(posedge clk) begin
		if (vis_we)
			vis_mem[vis_wa] <= vis_wd;
		vis_rd_q <= vis_mem[vis_ra];
	end

	always_ff @(posedge clk) begin
		if (add_ok) begin
			src_mem[edges_q[EAW-1:0]] <= a_idx;
			tgt_mem[edges_q[EAW-1:0]] <= b_idx;
		end
		src_rd_q <= src_mem[cur_e_q[EAW-1:0]];
		tgt_rd_q <= tgt_mem[cur_e_q[EAW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (state_q == S_SCAN && !edge_cnt_lt && !rev_q)
			fin_mem[fin_q[VW-1:0]] <= cur_v_q;
		fin_rd_q <= fin_mem[VW'(i_q - (VW+1)'(1))];
	end

	always_ff @(posedge clk) begin
		if (state_q == S_SCAN && !edge_cnt_lt && rev_q)
			lab_mem[cur_v_q] <= count_q[VW-1:0];
		labA_q <= lab_mem[a_idx];
		labB_q <= lab_mem[b_idx];
	end

	always_ff @(posedge clk) begin
		if (state_q == S_VIS_CHK && !vis_rd_q) begin
			stkv_mem[VW'(sp_q - (VW+1)'(1))] <= cur_v_q;
			stke_mem[VW'(sp_q - (VW+1)'(1))] <= cur_e_q;
		end
		stkv_rd_q <= stkv_mem[VW'(sp_q - (VW+1)'(2))];
		stke_rd_q <= stke_mem[VW'(sp_q - (VW+1)'(2))];
	end

	// control and datapath registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			vc_q            <= VCOUNT_RST;
			built_q         <= 1'b0;
			edges_q         <= '0;
			comp_q          <= '0;
			result_valid    <= 1'b0;
			same_component  <= 1'b0;
			component_total <= '0;
			status          <= ST_OK;
			count_q         <= '0;
			fin_q           <= '0;
			rev_q           <= 1'b0;
			clr_q           <= '0;
			i_q             <= '0;
			sp_q            <= '0;
			cur_v_q         <= '0;
			cur_e_q         <= '0;
			to_q            <= '0;
		end else begin
			state_q      <= state_d;
			result_valid <= rv_d;
			if (cfg_wr && !paddr[2])
				vc_q <= pwdata[CNT_W-1:0];
			if ((cfg_wr && !paddr[2]) || add_ok)
				built_q <= 1'b0;
			else if (state_q == S_DONE)
				built_q <= 1'b1;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						same_component  <= 1'b0;
						component_total <= CNT_W'(comp_q);
						status          <= idle_status;
						count_q         <= '0;
						fin_q           <= '0;
						rev_q           <= 1'b0;
						clr_q           <= '0;
						if (add_ok)
							edges_q <= edges_q + EW'(1);
					end
				end
				S_QWAIT: same_component <= (labA_q == labB_q);
				S_CLR: begin
					clr_q <= clr_q + (VW+1)'(1);
					if (clr_q == (VW+1)'(MAX_VERTICES - 1))
						i_q <= rev_q ? fin_q : '0;
				end
				S_OUT_RD: begin
					if (!(32'(i_q) < 32'(n))) begin
						rev_q <= 1'b1;
						clr_q <= '0;
					end
				end
				S_OUT_CHK: begin
					if (vis_rd_q)
						i_q <= i_q + (VW+1)'(1);
					else begin
						cur_v_q <= i_q[VW-1:0];
						cur_e_q <= '0;
						sp_q    <= (VW+1)'(1);
					end
				end
				S_SCAN: begin
					if (edge_cnt_lt)
						cur_e_q <= cur_e_q + EW'(1);
					else begin
						if (!rev_q)
							fin_q <= fin_q + (VW+1)'(1);
						sp_q <= sp_q - (VW+1)'(1);
						if (walk_last) begin
							if (rev_q) begin
								count_q <= count_q + (VW+1)'(1);
								i_q     <= i_q - (VW+1)'(1);
							end else
								i_q <= i_q + (VW+1)'(1);
						end
					end
				end
				S_EDGE_CHK: to_q <= e_to;
				S_VIS_CHK: begin
					if (!vis_rd_q) begin
						cur_v_q <= to_q;
						cur_e_q <= '0;
						sp_q    <= sp_q + (VW+1)'(1);
					end
				end
				S_POP_WAIT: begin
					cur_v_q <= stkv_rd_q;
					cur_e_q <= stke_rd_q;
				end
				S_REV_RD: ;
				S_REV_VIS_RD: begin
					cur_v_q <= fin_rd_q;
					if (!(32'(fin_rd_q) < 32'(n)))
						i_q <= i_q - (VW+1)'(1);
				end
				S_REV_CHK: begin
					if (vis_rd_q)
						i_q <= i_q - (VW+1)'(1);
					else begin
						cur_e_q <= '0;
						sp_q    <= (VW+1)'(1);
					end
				end
				S_DONE: begin
					comp_q          <= count_q;
					component_total <= CNT_W'(count_q);
					status          <= ST_OK;
					same_component  <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	// checks
	a_sp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (32'(sp_q) <= MAX_VERTICES))
		else $error("walk stack overflow");
	a_done_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE) |=> (result_valid && built_q))
		else $error("build end without result");
	a_qwait_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_QWAIT) |=> result_valid)
		else $error("query without result");
	a_fin_bound: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> (32'(fin_q) <= MAX_VERTICES))
		else $error("finish order overflow");

endmodule

@@ test/testbench.sv @@
// Self-checking testbench for the strongly connected components block.
// It depends on scc_pkg and strongly_connected_components. An internal predictor builds the
// same component labels and checks each strobed result in order.
module testbench
	import scc_pkg::*;
;

	localparam int LIMIT    = 800000;
	localparam int NV       = MAX_VERTICES_DEF;
	localparam int NE       = MAX_EDGES_DEF;

	// Expected contents of one result transaction
	typedef struct {
		logic        same;
		logic [10:0] total;
		status_t     stat;
	} scc_result_t;

	// Scoreboard: predicts the graph state and compares strobed results
	class scc_scoreboard;
		int unsigned vcount = 1024;
		int          src_v[NE];
		int          dst_v[NE];
		int          loaded = 0;
		bit          built = 0;
		int          comps = 0;
		int          label[NV];
		int          order[NV];
		int          fin;
		bit          seen[NV];
		int          stk_v[NV];
		int          stk_e[NV];
		int          errors = 0;
		scc_result_t pending[$];

		task report(string msg);
			$display("ERROR %0t: %s", $time, msg);
			errors++;
		endtask

		function int active_n();
			return (vcount > NV) ? NV : vcount;
		endfunction

		function void set_count(logic [10:0] v);
			vcount = v;
			built  = 0;
		endfunction

		// Iterative depth-first walk; forward records finish order, reverse labels
		function void walk(int root, bit rev, int n, int lab);
			int sp, v, e, fr, to;
			bit pushed;
			seen[root] = 1;
			stk_v[0] = root;
			stk_e[0] = 0;
			sp = 1;
			while (sp > 0) begin
				v = stk_v[sp-1];
				e = stk_e[sp-1];
				pushed = 0;
				while (e < loaded) begin
					fr = rev ? dst_v[e] : src_v[e];
					to = rev ? src_v[e] : dst_v[e];
					e++;
					if (fr == v && to < n && !seen[to] && sp < NV) begin
						seen[to] = 1;
						stk_e[sp-1] = e;
						stk_v[sp] = to;
						stk_e[sp] = 0;
						sp++;
						pushed = 1;
						break;
					end
				end
				if (!pushed) begin
					sp--;
					if (rev)
						label[v] = lab;
					else if (fin < NV) begin
						order[fin] = v;
						fin++;
					end
				end
			end
		endfunction

		function void build_components();
			int n, cnt, v;
			n = active_n();
			fin = 0;
			cnt = 0;
			foreach (seen[i]) seen[i] = 0;
			for (int i = 0; i < n; i++)
				if (!seen[i]) walk(i, 0, n, 0);
			foreach (seen[i]) seen[i] = 0;
			for (int i = fin; i > 0; i--) begin
				v = order[i-1];
				if (v < n && !seen[v]) begin
					walk(v, 1, n, cnt);
					cnt++;
				end
			end
			comps = cnt;
			built = 1;
		endfunction

		// Accepted input transaction: update state and queue the expected result
		function void note_item(cmd_t c, logic [10:0] a, logic [10:0] b);
			scc_result_t r;
			int n;
			bit ok;
			n = active_n();
			ok = a >= 1 && a <= n && b >= 1 && b <= n;
			r.same = 0;
			r.stat = ST_OK;
			case (c)
				CMD_ADD: begin
					if (!ok) r.stat = ST_RANGE;
					else if (loaded >= NE) r.stat = ST_FULL;
					else begin
						src_v[loaded] = a - 1;
						dst_v[loaded] = b - 1;
						loaded++;
						built = 0;
					end
				end
				CMD_BUILD: build_components();
				CMD_QUERY: begin
					if (!ok) r.stat = ST_RANGE;
					else if (!built) r.stat = ST_NOT_BUILT;
					else r.same = label[a-1] == label[b-1];
				end
				default: ;
			endcase
			r.total = comps[10:0];
			pending.insert(pending.size(), r);
		endfunction

		task check_result(logic same, logic [10:0] total, logic [1:0] stat);
			scc_result_t r;
			if (pending.size() == 0) begin
				report("result strobed with nothing expected");
				return;
			end
			r = pending.pop_front();
			if (same !== r.same)
				report($sformatf("same_component %b, expected %b", same, r.same));
			if (total !== r.total)
				report($sformatf("component_total %0d, expected %0d", total, r.total));
			if (stat !== r.stat)
				report($sformatf("status %0d, expected %0d", stat, r.stat));
		endtask
	endclass

	logic        clk = 0;
	logic        arst_n = 0;
	logic        start = 0;
	logic [1:0]  command = CMD_NOP;
	logic [10:0] vertex_a = 0;
	logic [10:0] vertex_b = 0;
	logic        busy, result_valid, same_component, pready;
	logic [10:0] component_total;
	logic [1:0]  status;
	logic        psel = 0, penable = 0, pwrite = 0;
	logic [2:0]  paddr = 0;
	logic [31:0] pwdata = 0;
	logic [31:0] prdata;

	scc_scoreboard sb = new();
	bit  took = 0;
	int  quiet = 0;
	int  idle_pct = 0;

	strongly_connected_components i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .command(command),
		.vertex_a(vertex_a), .vertex_b(vertex_b), .busy(busy),
		.result_valid(result_valid), .same_component(same_component),
		.component_total(component_total), .status(status),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	// Monitor: results first, then the newly accepted transaction; watchdog
	always @(posedge clk) begin
		took = arst_n && start && !busy;
		if (arst_n && result_valid)
			sb.check_result(same_component, component_total, status);
		if (took)
			sb.note_item(cmd_t'(command), vertex_a, vertex_b);
		if (took || result_valid) quiet = 0;
		else quiet++;
		if (quiet >= LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Called at a falling edge; returns at the falling edge after acceptance, or after a random idle gap
	task send(cmd_t c, logic [10:0] a, logic [10:0] b);
		start    <= 1;
		command  <= c;
		vertex_a <= a;
		vertex_b <= b;
		do @(negedge clk); while (!took);
		if ($urandom_range(1, 100) <= idle_pct) begin
			start <= 0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
	endtask

	task drain();
		start <= 0;
		do @(negedge clk); while (sb.pending.size() != 0 || busy);
		repeat (4) @(negedge clk);
	endtask

	task write_count(logic [10:0] v);
		drain();
		psel    <= 1;
		pwrite  <= 1;
		penable <= 0;
		paddr   <= 0;
		pwdata  <= ($urandom() & 32'hFFFF_F800) | {21'd0, v};
		@(negedge clk);
		penable <= 1;
		@(negedge clk);
		psel    <= 0;
		penable <= 0;
		pwrite  <= 0;
		sb.set_count(v);
	endtask

	// Mostly a vertex in range, sometimes any 11-bit value
	function logic [10:0] pick(int n);
		if (n > 0 && $urandom_range(1, 100) <= 90)
			return 11'($urandom_range(1, (n > NV) ? NV : n));
		return 11'($urandom_range(0, 2047));
	endfunction

	task random_round();
		int n;
		n = ($urandom_range(1, 10) == 1) ? $urandom_range(9, 20) : $urandom_range(1, 8);
		if ($urandom_range(1, 3) == 1) write_count(11'(n));
		else n = sb.active_n();
		if (n > 20) begin
			write_count(8);
			n = 8;
		end
		repeat ($urandom_range(2, 10)) send(CMD_ADD, pick(n), pick(n));
		send(CMD_BUILD, 11'($urandom()), 11'($urandom()));
		repeat ($urandom_range(8, 22)) begin
			case ($urandom_range(1, 20))
				1:       send(CMD_ADD, pick(n), pick(n));
				2:       send(CMD_NOP, 11'($urandom()), 11'($urandom()));
				3:       send(cmd_t'($urandom_range(0, 3)), 11'($urandom()),
						11'($urandom()));
				default: send(CMD_QUERY, pick(n), pick(n));
			endcase
		end
	endtask

	initial begin
		repeat (2) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// Directed: range errors, unused code, queries before a build, vertex 1024 at full count
		send(CMD_QUERY, 1, 2);
		send(CMD_QUERY, 0, 5);
		send(CMD_QUERY, 3, 2047);
		send(CMD_NOP, 11'h7FF, 11'h7FF);
		send(CMD_ADD, 0, 5);
		send(CMD_ADD, 5, 1025);
		send(CMD_ADD, 1, 2);
		send(CMD_ADD, 2, 1);
		send(CMD_ADD, 1024, 1024);
		send(CMD_ADD, 1024, 1);
		send(CMD_ADD, 3, 1024);
		send(CMD_BUILD, 0, 0);
		send(CMD_QUERY, 1, 2);
		send(CMD_QUERY, 1, 1024);
		send(CMD_QUERY, 3, 1024);
		send(CMD_QUERY, 1024, 1024);
		send(CMD_ADD, 2, 3);
		send(CMD_QUERY, 1, 2);
		// Zero count: nothing in range, build finds nothing
		write_count(0);
		send(CMD_BUILD, 0, 0);
		send(CMD_QUERY, 1, 1);
		// Count above the maximum is clamped; old labels are stale
		write_count(11'h7FF);
		send(CMD_QUERY, 1, 2);
		send(CMD_BUILD, 0, 0);
		send(CMD_QUERY, 1024, 3);
		write_count(1);
		send(CMD_BUILD, 0, 0);
		send(CMD_QUERY, 1, 1);

		// Random rounds under three sender idle profiles
		idle_pct = 31;
		repeat (15) random_round();
		idle_pct = 47;
		repeat (15) random_round();
		idle_pct = 0;
		repeat (15) random_round();

		// Final build over everything loaded
		write_count(2);
		send(CMD_BUILD, 0, 0);
		send(CMD_QUERY, 1, 2);
		send(CMD_QUERY, 2, 2);

		drain();
		repeat (8) @(negedge clk);
		if (sb.errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule
